// ===== rtl/swsend_pkg.sv =====
`default_nettype none

package swsend_pkg;

    // Sequence space and window sizing
    localparam int SEQ_BITS     = 3;
    localparam int SEQ_SPACE    = 1 << SEQ_BITS;
    localparam int WINDOW_LIMIT = 4;
    localparam int DATA_BITS    = 64;
    localparam int FIELD_BITS   = 64;

    // Duplicate ACK count that triggers a fast retransmit
    localparam logic [1:0] DUP_TRIGGER = 2'd3;

    // Event codes on the mode field
    localparam logic [1:0] MODE_SEND    = 2'd0;
    localparam logic [1:0] MODE_ACK     = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    typedef logic [SEQ_BITS-1:0] seq_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [FIELD_BITS-1:0] payload;
        logic [2:0]            ack_number;
        logic                  ack_intact;
    } in_t;

    typedef struct packed {
        logic                  accepted;
        logic                  transmit;
        logic [2:0]            transmit_seq;
        logic [FIELD_BITS-1:0] transmit_data;
        logic                  timer_stop;
        logic [2:0]            stop_seq;
        logic                  timer_start;
        logic [2:0]            start_seq;
        logic                  window_full;
    } out_t;

endpackage

`default_nettype wire

// ===== rtl/sliding_window_sender_core.sv =====
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    in_t  (mode, payload, ack_number, ack_intact)
// m_        out  m_valid/m_ready    out_t (one result per event)
//
// One event per cycle sustained while the result is not stalled; a result passes
// through the s1 stage and the output register before it is presented.
// Window state updates in the accept cycle; the unacked buffer is read there and
// its registered data joins the result in the s1 stage.
// Reset (aresetn low, synchronous) clears window state and the buffer valid bits.
// A stalled result holds the pipeline; s_ready drops only when both stages are full and m_ready is low.

module sliding_window_sender_core
    import swsend_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    typedef struct packed {
        logic accepted;
        logic transmit;
        seq_t transmit_seq;
        logic timer_stop;
        seq_t stop_seq;
        logic timer_start;
        seq_t start_seq;
        logic window_full;
        logic from_store;
        logic entry_valid;
    } stage_t;

    seq_t                   base_reg, base_next;
    seq_t                   next_seq_reg, next_seq_next;
    logic [1:0]             dup_reg, dup_next;
    logic                   full_reg, full_next;
    logic [SEQ_SPACE-1:0]   ent_valid_reg;

    logic                   s1_valid_reg;
    stage_t                 s1_reg, stage_next;
    logic [DATA_BITS-1:0]   s1_data_reg, data_next;

    logic                   m_valid_reg;
    out_t                   m_data_reg, m_data_next;

    logic                   s_fire, s1_adv;
    logic                   ram_we, ram_re;
    logic [DATA_BITS-1:0]   ram_rdata;
    seq_t                   seq_inc, seq_diff, ack_seq;
    logic [1:0]             dup_inc;

    assign s1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_fire  = s_valid && s_ready;
    assign ack_seq = s_data.ack_number[SEQ_BITS-1:0];

    // Event decode and window update
    always_comb begin
        base_next     = base_reg;
        next_seq_next = next_seq_reg;
        dup_next      = dup_reg;
        full_next     = full_reg;
        stage_next    = '0;
        data_next     = '0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        seq_inc       = next_seq_reg + 1'b1;
        seq_diff      = seq_inc - base_reg;
        dup_inc       = (dup_reg < DUP_TRIGGER) ? dup_reg + 2'd1 : dup_reg;

        if (s_fire) begin
            case (s_data.mode)
                MODE_SEND: begin
                    if (!full_reg) begin
                        ram_we                  = 1'b1;
                        stage_next.accepted     = 1'b1;
                        stage_next.transmit     = 1'b1;
                        stage_next.transmit_seq = next_seq_reg;
                        data_next               = s_data.payload[DATA_BITS-1:0];
                        if (base_reg == next_seq_reg) begin
                            stage_next.timer_start = 1'b1;
                            stage_next.start_seq   = base_reg;
                        end
                        next_seq_next = seq_inc;
                        if (32'(seq_diff) >= 32'(WINDOW_LIMIT)) begin
                            full_next = 1'b1;
                        end
                    end
                end
                MODE_ACK: begin
                    if (s_data.ack_intact) begin
                        if (ack_seq == base_reg) begin
                            if (dup_inc >= DUP_TRIGGER) begin
                                ram_re                  = 1'b1;
                                stage_next.timer_stop   = 1'b1;
                                stage_next.stop_seq     = base_reg;
                                stage_next.timer_start  = 1'b1;
                                stage_next.start_seq    = base_reg;
                                stage_next.transmit     = 1'b1;
                                stage_next.transmit_seq = base_reg;
                                stage_next.from_store   = 1'b1;
                                stage_next.entry_valid  = ent_valid_reg[base_reg];
                                dup_next                = '0;
                            end else begin
                                dup_next = dup_inc;
                            end
                        end else begin
                            stage_next.timer_stop = 1'b1;
                            stage_next.stop_seq   = base_reg;
                            base_next             = ack_seq;
                            dup_next              = 2'd1;
                            if (ack_seq != next_seq_reg) begin
                                stage_next.timer_start = 1'b1;
                                stage_next.start_seq   = ack_seq;
                            end
                            full_next = 1'b0;
                        end
                    end
                end
                MODE_TIMEOUT: begin
                    ram_re                  = 1'b1;
                    stage_next.timer_stop   = 1'b1;
                    stage_next.stop_seq     = base_reg;
                    stage_next.timer_start  = 1'b1;
                    stage_next.start_seq    = base_reg;
                    stage_next.transmit     = 1'b1;
                    stage_next.transmit_seq = base_reg;
                    stage_next.from_store   = 1'b1;
                    stage_next.entry_valid  = ent_valid_reg[base_reg];
                    dup_next                = '0;
                end
                default: begin
                end
            endcase
            stage_next.window_full = full_next;
        end
    end

    // Unacked payload buffer
    swsend_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (SEQ_SPACE)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (next_seq_reg),
        .wdata (s_data.payload[DATA_BITS-1:0]),
        .re    (ram_re),
        .raddr (base_reg),
        .rdata (ram_rdata)
    );

    // Result assembly; a never-written slot reads as zero
    always_comb begin
        m_data_next               = '0;
        m_data_next.accepted      = s1_reg.accepted;
        m_data_next.transmit      = s1_reg.transmit;
        m_data_next.transmit_seq  = 3'(s1_reg.transmit_seq);
        m_data_next.timer_stop    = s1_reg.timer_stop;
        m_data_next.stop_seq      = 3'(s1_reg.stop_seq);
        m_data_next.timer_start   = s1_reg.timer_start;
        m_data_next.start_seq     = 3'(s1_reg.start_seq);
        m_data_next.window_full   = s1_reg.window_full;
        if (s1_reg.from_store) begin
            m_data_next.transmit_data = s1_reg.entry_valid ? FIELD_BITS'(ram_rdata) : '0;
        end else begin
            m_data_next.transmit_data = FIELD_BITS'(s1_data_reg);
        end
    end

    // Window state and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            next_seq_reg  <= '0;
            dup_reg       <= '0;
            full_reg      <= 1'b0;
            ent_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            base_reg     <= base_next;
            next_seq_reg <= next_seq_next;
            dup_reg      <= dup_next;
            full_reg     <= full_next;
            if (ram_we) begin
                ent_valid_reg[next_seq_reg] <= 1'b1;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_reg      <= stage_next;
            s1_data_reg <= data_next;
        end
        if (s1_valid_reg && s1_adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/swsend_ram.sv =====
`default_nettype none

module swsend_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; read data holds until the next read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/swsend_chk.sv =====
`default_nettype none

module swsend_chk
    import swsend_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A taken send transmits and never stops a timer
    a_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accepted |-> m_data.transmit && !m_data.timer_stop)
        else $error("accepted send without transmit or with timer stop");

    // Retransmissions restart the timer of the packet they resend
    a_retx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.transmit && m_data.timer_stop |->
            m_data.timer_start && m_data.start_seq == m_data.transmit_seq &&
            m_data.stop_seq == m_data.transmit_seq)
        else $error("retransmit timer sequence mismatch");

    // No transmission means empty packet fields
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.transmit |->
            m_data.transmit_seq == 3'd0 && m_data.transmit_data == '0)
        else $error("packet fields set without transmit");

endmodule

bind sliding_window_sender_core swsend_chk u_swsend_chk (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb
    import swsend_pkg::*;
();

    // mode 3 has no meaning in the block and must be ignored
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [FIELD_BITS-1:0] DATA_MASK = {FIELD_BITS{1'b1}} >> (FIELD_BITS - DATA_BITS);

    // results that can be read straight off the protocol rules
    localparam out_t QUIET_OUT    = '0;
    localparam out_t QUIET_FULL   = '{window_full: 1'b1, default: '0};
    localparam out_t RESET_RESEND = '{transmit: 1'b1, timer_stop: 1'b1, timer_start: 1'b1,
                                      default: '0};
    localparam out_t FIRST_SEND   = '{accepted: 1'b1, transmit: 1'b1, transmit_data: '1,
                                      timer_start: 1'b1, default: '0};

    typedef struct {
        in_t  ev;
        bit   typed;
        out_t want;
    } row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    sliding_window_sender_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Predicted sender state
    seq_t                  win_base;
    seq_t                  win_next;
    logic [1:0]            dup_acks;
    logic                  win_full;
    logic [FIELD_BITS-1:0] unacked [SEQ_SPACE];

    out_t pending_results [$];
    out_t oldest;
    int   mismatch_cnt = 0;
    int   cycle_cnt = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic in_t ev_of(logic [1:0] m, logic [FIELD_BITS-1:0] pl, seq_t ak,
                                  logic ok);
        in_t e;
        e.mode       = m;
        e.payload    = pl;
        e.ack_number = ak;
        e.ack_intact = ok;
        return e;
    endfunction

    function automatic row_t dir_row(in_t ev, bit typed, out_t want);
        row_t r;
        r.ev    = ev;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Stop and restart the base timer and resend the base slot
    function automatic out_t resend_base(out_t r);
        r.timer_stop    = 1'b1;
        r.stop_seq      = win_base;
        r.timer_start   = 1'b1;
        r.start_seq     = win_base;
        r.transmit      = 1'b1;
        r.transmit_seq  = win_base;
        r.transmit_data = unacked[win_base] & DATA_MASK;
        dup_acks        = '0;
        return r;
    endfunction

    // One event through the window: updates state, returns the result
    function automatic out_t window_step(in_t ev);
        out_t r;
        seq_t n;
        r = '0;
        case (ev.mode)
            MODE_SEND: begin
                if (!win_full) begin
                    n               = win_next;
                    unacked[n]      = ev.payload & DATA_MASK;
                    r.accepted      = 1'b1;
                    r.transmit      = 1'b1;
                    r.transmit_seq  = n;
                    r.transmit_data = ev.payload & DATA_MASK;
                    if (win_base == n) begin
                        r.timer_start = 1'b1;
                        r.start_seq   = win_base;
                    end
                    win_next = n + 1'b1;
                    if (int'(seq_t'(win_next - win_base)) >= WINDOW_LIMIT)
                        win_full = 1'b1;
                end
            end
            MODE_ACK: begin
                if (ev.ack_intact) begin
                    if (ev.ack_number == win_base) begin
                        if (dup_acks < DUP_TRIGGER)
                            dup_acks = dup_acks + 1'b1;
                        if (dup_acks >= DUP_TRIGGER)
                            r = resend_base(r);
                    end else begin
                        // cumulative ACK, taken as the new base unchecked
                        r.timer_stop = 1'b1;
                        r.stop_seq   = win_base;
                        win_base     = ev.ack_number;
                        dup_acks     = 2'd1;
                        if (win_base != win_next) begin
                            r.timer_start = 1'b1;
                            r.start_seq   = win_base;
                        end
                        win_full = 1'b0;
                    end
                end
            end
            MODE_TIMEOUT: begin
                r = resend_base(r);
            end
            default: ;
        endcase
        r.window_full = win_full;
        return r;
    endfunction

    // Present one event, hold it until the transfer, then log its expectation
    task automatic offer(in_t ev, bit typed, out_t want);
        out_t guess;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= ev;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        guess = window_step(ev);
        pending_results.push_back(typed ? want : guess);
    endtask

    task automatic pause(int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    function automatic void check_field(string name, logic [FIELD_BITS-1:0] exp,
                                        logic [FIELD_BITS-1:0] act);
        if (exp !== act) begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp, act);
            mismatch_cnt++;
        end
    endfunction

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending, expected none got %p",
                         $time, m_data);
                mismatch_cnt++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("accepted", FIELD_BITS'(oldest.accepted),
                            FIELD_BITS'(m_data.accepted));
                check_field("transmit", FIELD_BITS'(oldest.transmit),
                            FIELD_BITS'(m_data.transmit));
                check_field("transmit_seq", FIELD_BITS'(oldest.transmit_seq),
                            FIELD_BITS'(m_data.transmit_seq));
                check_field("transmit_data", oldest.transmit_data, m_data.transmit_data);
                check_field("timer_stop", FIELD_BITS'(oldest.timer_stop),
                            FIELD_BITS'(m_data.timer_stop));
                check_field("stop_seq", FIELD_BITS'(oldest.stop_seq),
                            FIELD_BITS'(m_data.stop_seq));
                check_field("timer_start", FIELD_BITS'(oldest.timer_start),
                            FIELD_BITS'(m_data.timer_start));
                check_field("start_seq", FIELD_BITS'(oldest.start_seq),
                            FIELD_BITS'(m_data.start_seq));
                check_field("window_full", FIELD_BITS'(oldest.window_full),
                            FIELD_BITS'(m_data.window_full));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: long ready stretches mixed with short stalls
    initial begin
        int run;
        bit rdy;
        run     = 0;
        rdy     = 1'b0;
        m_ready = 1'b0;
        forever begin
            if (run == 0) begin
                case ($urandom_range(0, 9))
                    0: begin
                        rdy = 1'b1;
                        run = 100;
                    end
                    1, 2, 3, 4, 5: begin
                        rdy = 1'b1;
                        run = $urandom_range(1, 30);
                    end
                    default: begin
                        rdy = 1'b0;
                        run = $urandom_range(1, 5);
                    end
                endcase
            end
            @(negedge aclk);
            m_ready <= rdy;
            run--;
        end
    end

    // Stimulus
    initial begin
        row_t dir_rows [$];
        in_t  ev;
        int   effective;
        int   burst;
        int   outstanding;
        int   pick;
        bit   drained;

        s_valid  = 1'b0;
        s_data   = '0;
        aresetn  = 1'b0;
        win_base = '0;
        win_next = '0;
        dup_acks = '0;
        win_full = 1'b0;
        foreach (unacked[i])
            unacked[i] = '0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // timeout right after reset resends the cleared base slot
        dir_rows.push_back(dir_row(ev_of(MODE_TIMEOUT, '0, 3'd0, 1'b0), 1'b1, RESET_RESEND));
        dir_rows.push_back(dir_row(ev_of(MODE_UNUSED, '1, 3'd7, 1'b1), 1'b1, QUIET_OUT));
        dir_rows.push_back(dir_row(ev_of(MODE_ACK, '0, 3'd5, 1'b0), 1'b1, QUIET_OUT));
        // fill the window
        dir_rows.push_back(dir_row(ev_of(MODE_SEND, '1, 3'd0, 1'b0), 1'b1, FIRST_SEND));
        dir_rows.push_back(dir_row(ev_of(MODE_SEND, '0, 3'd7, 1'b1), 1'b0, QUIET_OUT));
        dir_rows.push_back(dir_row(ev_of(MODE_SEND, 64'hA5A5_5A5A_0F0F_F0F0, 3'd2, 1'b0),
                                   1'b0, QUIET_OUT));
        dir_rows.push_back(dir_row(ev_of(MODE_SEND, 64'h8000_0000_0000_0001, 3'd0, 1'b1),
                                   1'b0, QUIET_OUT));
        // refused send and corrupt ACK while full
        dir_rows.push_back(dir_row(ev_of(MODE_SEND, 64'h1234, 3'd0, 1'b0), 1'b1, QUIET_FULL));
        dir_rows.push_back(dir_row(ev_of(MODE_ACK, '0, 3'd2, 1'b0), 1'b1, QUIET_FULL));
        // three duplicates of base from a fresh count
        repeat (3)
            dir_rows.push_back(dir_row(ev_of(MODE_ACK, '0, 3'd0, 1'b1), 1'b0, QUIET_OUT));
        // cumulative ACK, then two duplicates trigger fast retransmit
        repeat (3)
            dir_rows.push_back(dir_row(ev_of(MODE_ACK, '0, 3'd2, 1'b1), 1'b0, QUIET_OUT));
        dir_rows.push_back(dir_row(ev_of(MODE_TIMEOUT, '1, 3'd5, 1'b1), 1'b0, QUIET_OUT));
        // drain the window, then time out on an empty window
        dir_rows.push_back(dir_row(ev_of(MODE_ACK, '0, 3'd4, 1'b1), 1'b0, QUIET_OUT));
        dir_rows.push_back(dir_row(ev_of(MODE_TIMEOUT, '0, 3'd0, 1'b0), 1'b0, QUIET_OUT));
        // ACK outside the window moves base anyway
        dir_rows.push_back(dir_row(ev_of(MODE_ACK, '0, 3'd7, 1'b1), 1'b0, QUIET_OUT));
        dir_rows.push_back(dir_row(ev_of(MODE_SEND, 64'h0123_4567_89AB_CDEF, 3'd1, 1'b0),
                                   1'b0, QUIET_OUT));
        dir_rows.push_back(dir_row(ev_of(MODE_SEND, 64'hFEDC_BA98_7654_3210, 3'd6, 1'b1),
                                   1'b0, QUIET_OUT));
        dir_rows.push_back(dir_row(ev_of(MODE_ACK, '0, 3'd4, 1'b1), 1'b0, QUIET_OUT));
        dir_rows.push_back(dir_row(ev_of(MODE_SEND, '0, 3'd3, 1'b1), 1'b0, QUIET_OUT));
        dir_rows.push_back(dir_row(ev_of(MODE_UNUSED, '0, 3'd0, 1'b0), 1'b0, QUIET_OUT));

        foreach (dir_rows[i])
            offer(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);

        // Random traffic: mostly in-window sends and ACKs, some noise
        effective = 0;
        burst     = 0;
        drained   = 1'b0;
        while (effective < RANDOM_ITEMS) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                    pause($urandom_range(1, 8));
            end
            // halfway through, let everything in flight come out
            if (!drained && effective >= RANDOM_ITEMS / 2) begin
                pause(1);
                while (pending_results.size() != 0)
                    @(negedge aclk);
                drained = 1'b1;
            end

            outstanding = int'(seq_t'(win_next - win_base));
            ev   = ev_of(MODE_ACK, {$urandom, $urandom}, seq_t'($urandom), 1'b1);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                ev.mode       = MODE_SEND;
                ev.ack_intact = 1'($urandom_range(0, 1));
            end else if (pick < 75) begin
                if (pick < 55 && outstanding != 0)
                    ev.ack_number = win_base + seq_t'($urandom_range(1, outstanding));
                else if (pick < 70)
                    ev.ack_number = win_base;
            end else if (pick < 85) begin
                ev.mode       = MODE_TIMEOUT;
                ev.ack_intact = 1'($urandom_range(0, 1));
            end else if (pick < 94) begin
                ev.ack_intact = 1'b0;
            end else begin
                ev.mode       = MODE_UNUSED;
                ev.ack_intact = 1'($urandom_range(0, 1));
            end

            effective++;
            offer(ev, 1'b0, QUIET_OUT);
            burst--;
        end

        // wind down
        pause(1);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
